// ===== design/mrbo_pkg.sv =====
// shared constants and codes for the multi ring buffer block
package mrbo_pkg;

  localparam int unsigned NUM_BUFFERS_DEF = 4;
  localparam int unsigned DEPTH_DEF       = 16;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ERR_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd2;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_INDEX = 2'd1;
  localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

endpackage

// ===== design/multi_ring_buffer_overwrite_core.sv =====
// top level of the bank of overwriting byte ring buffers
//
// a bank of NUM_BUFFERS byte ring buffers, each DEPTH slots with one slot
// kept open, so a buffer holds at most DEPTH-1 bytes
// input channel s_*: one item names a buffer and an operation (push, pop,
// status); every accepted item gives exactly one result item on m_*
// a push into a full buffer drops the oldest byte and flags overwrote
// an out-of-range index or a pop from an empty buffer returns an error code
// pointers live in flip-flops per buffer, bytes in one synchronous ram
// with a registered read port
// push, status and refused items give their result straight from the output
// register; a good pop first passes the ram read register and S_READ
// throughput: one item per cycle for push and status while the receiver
// keeps up; after a good pop the input waits until S_READ is over
// the result sits in an output register; a new item is taken while idle
// and that register is empty or being drained in the same cycle, so a stalled
// receiver holds off the input after one waiting result
// reset clears all pointers (every buffer empty) and the output valid;
// ram contents are never read before written, so they need no clearing
module multi_ring_buffer_overwrite_core #(
  parameter int unsigned NUM_BUFFERS = mrbo_pkg::NUM_BUFFERS_DEF,
  parameter int unsigned DEPTH       = mrbo_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // func [1:0], buffer_index [5:2], data_in [13:6], zero [15:14]
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // data_out [7:0], is_full [8], is_empty [9], overwrote [10],
  // error_code [12:11], zero [15:13]
  output logic [15:0] m_tdata
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned AW = BW + PW;
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // item fields
  logic [mrbo_pkg::FUNC_W-1:0] func;
  logic [mrbo_pkg::IDX_W-1:0]  buffer_index;
  logic [mrbo_pkg::BYTE_W-1:0] data_in;
  assign func         = s_tdata[1:0];
  assign buffer_index = s_tdata[5:2];
  assign data_in      = s_tdata[13:6];

  mrbo_pkg::state_t state;

  // per-buffer pointers
  logic [PW-1:0] rd_ptr [NUM_BUFFERS];
  logic [PW-1:0] wr_ptr [NUM_BUFFERS];

  // byte ram
  logic [mrbo_pkg::BYTE_W-1:0] mem [2**AW];
  logic [mrbo_pkg::BYTE_W-1:0] rd_data;

  // output register
  logic [mrbo_pkg::BYTE_W-1:0] out_data;
  logic                        out_full;
  logic                        out_empty;
  logic                        out_over;
  logic [mrbo_pkg::ERR_W-1:0]  out_err;

  logic          accept;
  logic          in_range;
  logic [BW-1:0] idx;
  logic [PW-1:0] rp;
  logic [PW-1:0] wp;
  logic [PW-1:0] rp_next;
  logic [PW-1:0] wp_next;
  logic          over;
  logic          is_full;
  logic          is_empty;
  logic [mrbo_pkg::ERR_W-1:0] err;
  logic          mem_wr;
  logic          mem_rd;
  logic [AW-1:0] mem_addr;

  // take an item only when idle and the output register is free
  assign s_tready = (state == mrbo_pkg::S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign in_range = {1'b0, buffer_index} < 5'(NUM_BUFFERS);
  assign idx      = buffer_index[BW-1:0];
  assign rp       = rd_ptr[idx];
  assign wp       = wr_ptr[idx];

  always_comb begin
    rp_next = rp;
    wp_next = wp;
    over    = 1'b0;
    err     = mrbo_pkg::ERR_OK;
    mem_wr  = 1'b0;
    mem_rd  = 1'b0;
    if (!in_range) begin
      err = mrbo_pkg::ERR_BAD_INDEX;
    end else begin
      case (func)
        mrbo_pkg::FUNC_PUSH: begin
          mem_wr  = 1'b1;
          wp_next = next_slot(wp);
          // a full buffer drops its oldest byte
          if (next_slot(wp) == rp) begin
            rp_next = next_slot(rp);
            over    = 1'b1;
          end
        end
        mrbo_pkg::FUNC_POP: begin
          if (wp == rp) begin
            err = mrbo_pkg::ERR_POP_EMPTY;
          end else begin
            mem_rd  = 1'b1;
            rp_next = next_slot(rp);
          end
        end
        default: begin
          // status query and the unused code change nothing
        end
      endcase
    end
    is_full  = in_range && (next_slot(wp_next) == rp_next);
    is_empty = in_range && (wp_next == rp_next);
  end

  // ram address: buffer in the upper bits, slot in the lower
  assign mem_addr = {idx, mem_wr ? wp : rp};

  always_ff @(posedge clk) begin
    if (accept && mem_wr) begin
      mem[mem_addr] <= data_in;
    end
    if (accept && mem_rd) begin
      rd_data <= mem[mem_addr];
    end
  end

  // pointer update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
      end
    end else if (accept && in_range) begin
      rd_ptr[idx] <= rp_next;
      wr_ptr[idx] <= wp_next;
    end
  end

  // control: a good pop waits in S_READ for the ram data
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mrbo_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        mrbo_pkg::S_IDLE: begin
          if (accept) begin
            if (mem_rd) begin
              state    <= mrbo_pkg::S_READ;
              m_tvalid <= 1'b0;
            end else begin
              m_tvalid <= 1'b1;
            end
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        mrbo_pkg::S_READ: begin
          state    <= mrbo_pkg::S_IDLE;
          m_tvalid <= 1'b1;
        end
        default: begin
          state    <= mrbo_pkg::S_IDLE;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data  <= '0;
      out_full  <= is_full;
      out_empty <= is_empty;
      out_over  <= over;
      out_err   <= err;
    end else if (state == mrbo_pkg::S_READ) begin
      out_data <= rd_data;
    end
  end

  assign m_tdata = {3'b000, out_err, out_over, out_empty, out_full, out_data};

endmodule

// ===== tb/tb_multi_ring_buffer_overwrite_core.sv =====
// self-checking testbench for the overwriting multi ring buffer block
module tb_multi_ring_buffer_overwrite_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBUF  = mrbo_pkg::NUM_BUFFERS_DEF;
  localparam int unsigned SLOTS = mrbo_pkg::DEPTH_DEF;
  localparam int unsigned RANDOM_OPS = 660;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef logic [mrbo_pkg::FUNC_W-1:0] func_t;
  typedef logic [mrbo_pkg::IDX_W-1:0]  idx_t;
  typedef logic [mrbo_pkg::BYTE_W-1:0] byte_t;

  // opcode 3 is unused by the block and behaves as a status query
  localparam logic [mrbo_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

  // one input item, fields laid out as on s_tdata, listed from the highest bit down
  typedef struct packed {
    logic [mrbo_pkg::BYTE_W-1:0] data;
    logic [mrbo_pkg::IDX_W-1:0]  idx;
    logic [mrbo_pkg::FUNC_W-1:0] func;
  } op_t;

  // one result item
  typedef struct packed {
    logic [mrbo_pkg::BYTE_W-1:0] data;
    logic                        full;
    logic                        empty;
    logic                        over;
    logic [mrbo_pkg::ERR_W-1:0]  err;
  } result_t;

  // directed row: an op repeated count times with the byte stepping up,
  // and a typed-in result where it is obvious
  typedef struct packed {
    logic [mrbo_pkg::FUNC_W-1:0] func;
    logic [mrbo_pkg::IDX_W-1:0]  idx;
    logic [mrbo_pkg::BYTE_W-1:0] data;
    logic [4:0]                  count;
    logic                        typed;
    result_t                     want;
  } dir_row_t;

  localparam result_t NO_WANT  = '0;
  localparam result_t EMPTY_OK = '{8'h00, 1'b0, 1'b1, 1'b0, mrbo_pkg::ERR_OK};
  localparam result_t HOLDS_OK = '{8'h00, 1'b0, 1'b0, 1'b0, mrbo_pkg::ERR_OK};
  localparam result_t BAD_IDX  = '{8'h00, 1'b0, 1'b0, 1'b0, mrbo_pkg::ERR_BAD_INDEX};
  localparam result_t POP_NONE = '{8'h00, 1'b0, 1'b1, 1'b0, mrbo_pkg::ERR_POP_EMPTY};

  localparam int unsigned DIR_ROWS = 21;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // fresh buffers: empty, no data, pop from empty refused
    '{mrbo_pkg::FUNC_STATUS, 4'd0,  8'h00, 5'd1,  1'b1, EMPTY_OK},
    '{mrbo_pkg::FUNC_POP,    4'd0,  8'h00, 5'd1,  1'b1, POP_NONE},
    '{FUNC_SPARE,            4'd1,  8'hA5, 5'd1,  1'b1, EMPTY_OK},
    // index out of range, every operation
    '{mrbo_pkg::FUNC_STATUS, 4'd15, 8'h00, 5'd1,  1'b1, BAD_IDX},
    '{mrbo_pkg::FUNC_PUSH,   4'd4,  8'hFF, 5'd1,  1'b1, BAD_IDX},
    '{mrbo_pkg::FUNC_POP,    4'd8,  8'h00, 5'd1,  1'b1, BAD_IDX},
    '{FUNC_SPARE,            4'd12, 8'hFF, 5'd1,  1'b1, BAD_IDX},
    // extremes of the byte through one buffer
    '{mrbo_pkg::FUNC_PUSH,   4'd0,  8'h00, 5'd1,  1'b1, HOLDS_OK},
    '{mrbo_pkg::FUNC_PUSH,   4'd0,  8'hFF, 5'd1,  1'b0, NO_WANT},
    '{mrbo_pkg::FUNC_POP,    4'd0,  8'h00, 5'd1,  1'b0, NO_WANT},
    '{mrbo_pkg::FUNC_POP,    4'd0,  8'h00, 5'd1,  1'b0, NO_WANT},
    '{mrbo_pkg::FUNC_POP,    4'd0,  8'h00, 5'd1,  1'b1, POP_NONE},
    // fill buffer 3 past full so the two oldest bytes are dropped
    '{mrbo_pkg::FUNC_PUSH,   4'd3,  8'hA0, 5'd17, 1'b0, NO_WANT},
    '{mrbo_pkg::FUNC_STATUS, 4'd3,  8'h00, 5'd1,  1'b0, NO_WANT},
    '{mrbo_pkg::FUNC_PUSH,   4'd2,  8'h55, 5'd1,  1'b0, NO_WANT},
    '{mrbo_pkg::FUNC_PUSH,   4'd2,  8'hAA, 5'd1,  1'b0, NO_WANT},
    // drain buffer 3 and one pop beyond
    '{mrbo_pkg::FUNC_POP,    4'd3,  8'h00, 5'd16, 1'b0, NO_WANT},
    '{mrbo_pkg::FUNC_POP,    4'd2,  8'h00, 5'd2,  1'b0, NO_WANT},
    // exactly full without overwrite, then drain
    '{mrbo_pkg::FUNC_PUSH,   4'd1,  8'h01, 5'd15, 1'b0, NO_WANT},
    '{FUNC_SPARE,            4'd1,  8'h00, 5'd1,  1'b0, NO_WANT},
    '{mrbo_pkg::FUNC_POP,    4'd1,  8'h00, 5'd15, 1'b0, NO_WANT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  multi_ring_buffer_overwrite_core #(
    .NUM_BUFFERS(NBUF),
    .DEPTH      (SLOTS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #5 clk = ~clk;

  // predictor state: the bytes and both pointers of every buffer
  logic [mrbo_pkg::BYTE_W-1:0] byte_mem [NBUF][SLOTS];
  int unsigned                 rd_slot [NBUF];
  int unsigned                 wr_slot [NBUF];

  result_t     expected_q [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  // works out the result of one op and moves the predictor state
  function automatic result_t ring_bank_step(op_t op);
    result_t     r;
    int unsigned b;
    r = '0;
    b = op.idx;
    if (b >= NBUF) begin
      r.err = mrbo_pkg::ERR_BAD_INDEX;
      return r;
    end
    if (op.func == mrbo_pkg::FUNC_PUSH) begin
      byte_mem[b][wr_slot[b]] = op.data;
      wr_slot[b] = (wr_slot[b] + 1) % SLOTS;
      // caught up with the oldest byte: drop it
      if (wr_slot[b] == rd_slot[b]) begin
        rd_slot[b] = (rd_slot[b] + 1) % SLOTS;
        r.over = 1'b1;
      end
    end else if (op.func == mrbo_pkg::FUNC_POP) begin
      if (wr_slot[b] == rd_slot[b]) begin
        r.err = mrbo_pkg::ERR_POP_EMPTY;
      end else begin
        r.data = byte_mem[b][rd_slot[b]];
        rd_slot[b] = (rd_slot[b] + 1) % SLOTS;
      end
    end
    r.full  = ((wr_slot[b] + 1) % SLOTS) == rd_slot[b];
    r.empty = wr_slot[b] == rd_slot[b];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // presents one item in bursts with random gaps, queues its result once taken
  task automatic send_op(op_t op, logic typed, result_t want);
    int unsigned gap;
    result_t     pred;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = ring_bank_step(op);
    expected_q.push_back(typed ? want : pred);
    burst_left--;
  endtask

  // receiver backpressure: rx_mode picks one of five stall styles, redrawn at random as rx_tick runs
  int unsigned rx_mode = 0;
  int unsigned rx_tick = 0;
  always @(negedge clk) begin
    if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 4);
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      3: m_tready <= (rx_tick % 5 != 0);
      default: m_tready <= (rx_tick % 16 >= 10);
    endcase
  end

  // result checker
  result_t got;
  result_t want;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[10], m_tdata[12:11]};
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", m_tdata));
      end else begin
        want = expected_q.pop_front();
        if (got.data !== want.data)
          report_mismatch($sformatf("data_out %h, expected %h", got.data, want.data));
        if (got.full !== want.full)
          report_mismatch($sformatf("is_full %b, expected %b", got.full, want.full));
        if (got.empty !== want.empty)
          report_mismatch($sformatf("is_empty %b, expected %b", got.empty, want.empty));
        if (got.over !== want.over)
          report_mismatch($sformatf("overwrote %b, expected %b", got.over, want.over));
        if (got.err !== want.err)
          report_mismatch($sformatf("error_code %0d, expected %0d", got.err, want.err));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    op_t         op;
    int unsigned sent;
    int unsigned run_len;
    int unsigned kind;
    int unsigned b;
    for (int i = 0; i < NBUF; i++) begin
      rd_slot[i] = 0;
      wr_slot[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIR_TABLE[r]) begin
      for (int k = 0; k < DIR_TABLE[r].count; k++) begin
        op.func = DIR_TABLE[r].func;
        op.idx  = DIR_TABLE[r].idx;
        op.data = DIR_TABLE[r].data + k[mrbo_pkg::BYTE_W-1:0];
        send_op(op, DIR_TABLE[r].typed, DIR_TABLE[r].want);
      end
    end

    // random part: runs of pushes or pops on one buffer reach full,
    // overwrite and empty; mixed runs and noise cover the rest
    sent = 0;
    while (sent < RANDOM_OPS) begin
      kind = $urandom_range(0, 99);
      b    = $urandom_range(0, NBUF - 1);
      run_len = (kind < 65) ? $urandom_range(1, 20) : $urandom_range(1, 8);
      for (int k = 0; k < run_len; k++) begin
        op.data = byte_t'($urandom_range(0, 255));
        if (kind < 35) begin
          op.func = mrbo_pkg::FUNC_PUSH;
          op.idx  = idx_t'(b);
        end else if (kind < 65) begin
          op.func = mrbo_pkg::FUNC_POP;
          op.idx  = idx_t'(b);
        end else if (kind < 88) begin
          op.func = func_t'($urandom_range(0, 3));
          op.idx  = idx_t'($urandom_range(0, NBUF - 1));
        end else begin
          op.func = func_t'($urandom_range(0, 3));
          op.idx  = idx_t'($urandom_range(0, 15));
        end
        send_op(op, 1'b0, NO_WANT);
        sent++;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    // drain, then allow for anything stray the block still sends
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
